// ===== rtl/lsse_pkg.sv =====
// ----------------------------------------------------------------------------
// lsse_pkg
// Types and constants shared by the led strip spi encoder front, queue and
// back end.
// ----------------------------------------------------------------------------
package lsse_pkg;

  localparam int unsigned LEN_W = 7;   // byte count of one command, up to 64

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  localparam logic [1:0] MODE_APA102  = 2'd0;
  localparam logic [1:0] MODE_SK_RGB  = 2'd1;
  localparam logic [1:0] MODE_SK_RGBW = 2'd2;

  localparam logic [7:0] APA_HDR    = 8'hE0;
  localparam logic [7:0] SK_NIBBLES = 8'b1000_1000;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;
  localparam logic [7:0] BYTE_ZERO  = 8'h00;

  localparam logic [LEN_W-1:0] APA_PIX_LEN   = LEN_W'(4);
  localparam logic [LEN_W-1:0] APA_START_LEN = LEN_W'(4);
  localparam logic [LEN_W-1:0] SK_RGB_LEN    = LEN_W'(12);
  localparam logic [LEN_W-1:0] SK_RGBW_LEN   = LEN_W'(16);

  typedef enum logic [1:0] {
    OP_ZEROS = 2'd0,
    OP_ONES  = 2'd1,
    OP_APA   = 2'd2,
    OP_SK    = 2'd3
  } op_e;

  // one classified item: what to send and how many bytes
  typedef struct packed {
    op_e                   op;
    logic [LEN_W-1:0]      len;
    logic [3:0][7:0]       data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/lsse_front.sv =====
// ----------------------------------------------------------------------------
// lsse_front
// Accepts input items, keeps the pixel count and turns each item that makes
// bytes into a byte command for the back end.
// ----------------------------------------------------------------------------
module lsse_front #(
  parameter int unsigned MAX_PIXELS     = 1024,
  parameter int unsigned SK_FLUSH_BYTES = 51
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          white_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          bright_i,
  input  logic                q_full_i,
  output logic                push_o,
  output lsse_pkg::cmd_t      cmd_o
);
  import lsse_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             accept;
  logic             gen;
  logic             is_apa, is_sk;
  logic [CW:0]      cnt_rnd;
  logic [LEN_W-1:0] flush_len;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_apa     = (mode_i == MODE_APA102);
  assign is_sk      = (mode_i == MODE_SK_RGB) || (mode_i == MODE_SK_RGBW);

  // ceil(count / 16), at least one byte
  assign cnt_rnd   = {1'b0, cnt_q} + (CW+1)'(15);
  always_comb begin
    flush_len = LEN_W'(cnt_rnd >> 4);
    if (flush_len == '0) begin
      flush_len = LEN_W'(1);
    end
  end

  always_comb begin
    gen         = 1'b0;
    cnt_d       = cnt_q;
    cmd_o.op    = OP_ZEROS;
    cmd_o.len   = APA_START_LEN;
    cmd_o.data  = '0;
    unique case (kind_i)
      KIND_START: begin
        gen = is_apa;
      end
      KIND_PIXEL: begin
        if (is_apa) begin
          gen        = 1'b1;
          cmd_o.op   = OP_APA;
          cmd_o.len  = APA_PIX_LEN;
          cmd_o.data = {red_i, green_i, blue_i, APA_HDR | {3'b000, bright_i[7:3]}};
        end else if (is_sk) begin
          gen        = 1'b1;
          cmd_o.op   = OP_SK;
          cmd_o.len  = (mode_i == MODE_SK_RGBW) ? SK_RGBW_LEN : SK_RGB_LEN;
          cmd_o.data = {white_i, blue_i, red_i, green_i};
        end
        if (accept && (cnt_q < CW'(MAX_PIXELS))) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      KIND_END: begin
        if (is_apa) begin
          gen       = 1'b1;
          cmd_o.op  = OP_ONES;
          cmd_o.len = flush_len;
        end else if (is_sk) begin
          gen       = 1'b1;
          cmd_o.len = LEN_W'(SK_FLUSH_BYTES);
        end
        if (accept) begin
          cnt_d = '0;
        end
      end
      default: begin
        gen = 1'b0;
      end
    endcase
  end

  assign push_o = accept && gen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/lsse_queue.sv =====
// ----------------------------------------------------------------------------
// lsse_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module lsse_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  lsse_pkg::cmd_t      cmd_i,
  input  logic                pop_i,
  output lsse_pkg::cmd_t      cmd_o,
  output lsse_pkg::q_stat_t   stat_o
);
  import lsse_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/lsse_back.sv =====
// ----------------------------------------------------------------------------
// lsse_back
// Takes byte commands from the queue and sends them one byte per unstalled
// cycle through the output register, scaling and nibble-expanding sk6812 data.
// ----------------------------------------------------------------------------
module lsse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          bright_i,
  input  lsse_pkg::cmd_t      cmd_i,
  input  logic                q_empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          spi_byte_o,
  output logic                last_o
);
  import lsse_pkg::*;

  cmd_t             cmd_q;
  logic             busy_q;
  logic [LEN_W-1:0] idx_q;
  logic             out_valid_q, last_q;
  logic [7:0]       byte_q;

  logic             load, emit, is_last;
  logic [7:0]       chan, scaled, shifted, byte_d;
  logic [16:0]      prod;

  assign load    = !out_valid_q || !out_stall_i;
  assign emit    = busy_q && load;
  assign is_last = (idx_q == cmd_q.len - LEN_W'(1));
  assign pop_o   = !q_empty_i && (!busy_q || (emit && is_last));

  // sk6812: channel scaled by (level + 1) / 256, two data bits per byte
  assign chan    = cmd_q.data[idx_q[3:2]];
  assign prod    = 17'(chan) * 17'({1'b0, bright_i} + 9'd1);
  assign scaled  = prod[15:8];
  assign shifted = scaled << {idx_q[1:0], 1'b0};

  always_comb begin
    unique case (cmd_q.op)
      OP_ZEROS: byte_d = BYTE_ZERO;
      OP_ONES:  byte_d = BYTE_ONES;
      OP_APA:   byte_d = cmd_q.data[idx_q[1:0]];
      OP_SK:    byte_d = SK_NIBBLES | {1'b0, shifted[7], 3'b000, shifted[6], 2'b00};
      default:  byte_d = BYTE_ZERO;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
    if (emit) begin
      byte_q <= byte_d;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (load) begin
        out_valid_q <= 1'b0;
      end
      // a new command takes over straight after the last byte of the old one
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        idx_q <= idx_q + LEN_W'(1);
        if (is_last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign spi_byte_o  = byte_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/led_strip_spi_encoder.sv =====
// ----------------------------------------------------------------------------
// led_strip_spi_encoder
// Encodes frame start, pixel and frame end items into the spi byte stream
// of apa102 or sk6812 led strips.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries one item per transaction:
//   kind plus red, green, blue and white. output channel (out_valid_o /
//   out_stall_i) carries one spi byte per transaction, last_o marks the final
//   byte of an item. items that make no bytes (unknown kind, unknown mode,
//   sk6812 frame start) push no command and at most update the pixel count.
//   the configuration port writes strip_mode (index 0) or brightness
//   (index 1) on cfg_we_i; write only while the block is idle.
//   the first byte of an item passes through the queue, the back end's
//   command register and the output register. throughput is one byte per
//   cycle while the receiver does not stall, set by the single output
//   register: an apa102 pixel is 4 bytes, an sk6812 pixel 12 or 16, a
//   frame end 1 to 64 or the flush length. consecutive items follow each
//   other without a gap while the next is queued. a two-entry command
//   queue sits between input and output; when the receiver stalls, the
//   output holds and input is stalled once it fills. reset clears the
//   pixel count and the queue, sets apa102 mode and full brightness.
// ----------------------------------------------------------------------------
module led_strip_spi_encoder #(
  parameter int unsigned MAX_PIXELS     = 1024,
  parameter int unsigned SK_FLUSH_BYTES = 51
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] white_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] spi_byte_o,
  output logic       last_o
);
  import lsse_pkg::*;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_BRIGHT = 1'b1;

  logic [1:0] mode_q;
  logic [7:0] bright_q;
  logic       push, pop;
  cmd_t       push_cmd, pop_cmd;
  q_stat_t    q_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_APA102;
      bright_q <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q   <= cfg_data_i[1:0];
        CFG_BRIGHT: bright_q <= cfg_data_i;
        default:    mode_q   <= mode_q;
      endcase
    end
  end

  lsse_front #(
    .MAX_PIXELS     (MAX_PIXELS),
    .SK_FLUSH_BYTES (SK_FLUSH_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .white_i    (white_i),
    .mode_i     (mode_q),
    .bright_i   (bright_q),
    .q_full_i   (q_stat.full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lsse_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .stat_o (q_stat)
  );

  lsse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bright_i    (bright_q),
    .cmd_i       (pop_cmd),
    .q_empty_i   (q_stat.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .spi_byte_o  (spi_byte_o),
    .last_o      (last_o)
  );

  // no command is pushed into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("command pushed into full queue");

  // the back end never pops an empty queue
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("command popped from empty queue");

  // a push without a pop leaves the queue non-empty
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> !q_stat.empty)
    else $error("pushed command lost");

  // the input stays stalled while a full queue is not popped
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_stat.full && !pop) |=> in_stall_o)
    else $error("input taken while queue full");

endmodule
